// ===== src/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the bencode stream parser
// Token kinds, error codes, container codes and the token record.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // Nesting limit and its stack geometry.
    localparam int MaxDepth       = 256;
    localparam int DepthW         = $clog2(MaxDepth + 1);
    localparam int StackAddrW     = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
    localparam int MaxNumberChars = 20;
    localparam int CountW         = $clog2(MaxNumberChars + 1);

    // Kind of an emitted token.
    typedef enum logic [3:0] {
        KIND_INT  = 4'd0,
        KIND_BOOL = 4'd1,
        KIND_HDR  = 4'd2,
        KIND_BYTE = 4'd3,
        KIND_LIST = 4'd4,
        KIND_DICT = 4'd5,
        KIND_END  = 4'd6,
        KIND_ERR  = 4'd7,
        KIND_NONE = 4'd8
    } kind_t;

    // Error codes carried by error tokens.
    typedef enum logic [2:0] {
        ERR_UNKNOWN = 3'd0,
        ERR_BOOL    = 3'd1,
        ERR_INT     = 3'd2,
        ERR_LEN     = 3'd3,
        ERR_TRUNC   = 3'd4,
        ERR_DEEP    = 3'd5,
        ERR_KEY     = 3'd6
    } err_t;

    // Per-container state kept on the stack.
    typedef enum logic [1:0] {
        CTX_LIST = 2'd0,
        CTX_KEY  = 2'd1,
        CTX_VAL  = 2'd2,
        CTX_NONE = 2'd3
    } ctx_t;

    // One result token.
    typedef struct packed {
        logic [3:0]        token_kind;
        logic signed [63:0] token_value;
        logic [8:0]        nest_level;
        logic [2:0]        error_code;
        logic              message_done;
        logic              last_of_run;
    } token_t;

endpackage

// ===== src/bsp_byte_if.sv =====
// ----------------------------------------------------------------------------
// bsp_byte_if: input byte channel
// Valid/ready channel carrying one message byte with its framing marks.
// ----------------------------------------------------------------------------
interface bsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// ===== src/bsp_token_if.sv =====
// ----------------------------------------------------------------------------
// bsp_token_if: output token channel
// Valid/ready channel carrying one parser token.
// ----------------------------------------------------------------------------
interface bsp_token_if;
    logic               valid;
    logic               ready;
    logic [3:0]         token_kind;
    logic signed [63:0] token_value;
    logic [8:0]         nest_level;
    logic [2:0]         error_code;
    logic               message_done;
    logic               last_of_run;

    modport source (output valid, token_kind, token_value, nest_level, error_code,
                    message_done, last_of_run, input ready);
    modport sink   (input valid, token_kind, token_value, nest_level, error_code,
                    message_done, last_of_run, output ready);
endinterface

// ===== src/bencode_stream_parser.sv =====
// ----------------------------------------------------------------------------
// bencode_stream_parser: streaming bencode checker and tokenizer
// Parses one byte per cycle unless stalled; emits int, bool, string, container tokens.
// ----------------------------------------------------------------------------
// The parser takes one message byte per clock cycle and emits zero, one or two
// tokens for it into a four-entry output queue; it keeps taking bytes while
// tokens wait, and stalls only when the queue holds more than two tokens.
// The container stack lives in a 256-entry synchronous memory: the top entry
// sits in a register and the entry below it is prefetched every cycle, with a
// bypass for a push in the previous cycle, so pushes and pops run back to back.
module bencode_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    bsp_byte_if.sink    byte_in,
    bsp_token_if.source token_out
);

    typedef enum logic [3:0] {
        MODE_EXPECT   = 4'd0,
        MODE_INT_LEAD = 4'd1,
        MODE_INT_SIGN = 4'd2,
        MODE_INT_DIG  = 4'd3,
        MODE_LEN      = 4'd4,
        MODE_STR      = 4'd5,
        MODE_BOOL     = 4'd6,
        MODE_DONE     = 4'd7,
        MODE_FAILED   = 4'd8
    } mode_t;

    localparam int DW = bsp_pkg::DepthW;
    localparam int AW = bsp_pkg::StackAddrW;
    localparam int CW = bsp_pkg::CountW;

    // Stack memory and its prefetch path.
    logic [1:0]    stack_mem [bsp_pkg::MaxDepth];
    logic [1:0]    rdata_reg;
    logic          fwd_reg;
    logic [1:0]    fwd_data_reg;
    logic [1:0]    below;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;
    logic [AW-1:0] rd_addr;

    // Parser state.
    mode_t          mode_reg, mode_next, mode_e;
    logic [DW-1:0]  depth_reg, depth_next, depth_e;
    logic [63:0]    acc_reg, acc_next, acc_e;
    logic [CW-1:0]  cnt_reg, cnt_next, cnt_e;
    logic           neg_reg, neg_next, neg_e;
    logic [63:0]    rem_reg, rem_next, rem_e;
    logic [1:0]     top_reg, top_next;

    logic            accept;
    logic            room;
    logic            v0, v1;
    bsp_pkg::token_t t0, t1;
    logic [7:0]      c;
    logic            is_digit;
    logic            is_ws;
    logic [3:0]      dval;
    logic [1:0]      ctx;
    logic [67:0]     prod;
    logic [67:0]     limit;
    logic            fits;

    assign accept        = byte_in.valid && byte_in.ready;
    assign byte_in.ready = room;
    assign c             = byte_in.data_byte;
    assign is_digit      = (c >= "0") && (c <= "9");
    assign is_ws         = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    assign dval          = c[3:0];
    assign below         = fwd_reg ? fwd_data_reg : rdata_reg;

    // State seen by this byte, after an optional restart.
    always_comb
    begin
        if (byte_in.first_byte)
        begin
            mode_e  = MODE_EXPECT;
            depth_e = '0;
            acc_e   = '0;
            cnt_e   = '0;
            neg_e   = 1'b0;
            rem_e   = '0;
        end
        else
        begin
            mode_e  = mode_reg;
            depth_e = depth_reg;
            acc_e   = acc_reg;
            cnt_e   = cnt_reg;
            neg_e   = neg_reg;
            rem_e   = rem_reg;
        end
    end

    assign ctx = (depth_e != '0) ? top_reg : bsp_pkg::CTX_NONE;

    // Times-ten accumulate with the signed range check.
    assign prod  = ({4'd0, acc_e} << 3) + ({4'd0, acc_e} << 1) + {64'd0, dval};
    assign limit = (neg_e && (mode_e != MODE_LEN)) ? {4'd0, 64'h8000000000000000}
                                                   : {4'd0, 64'h7FFFFFFFFFFFFFFF};
    assign fits  = (prod <= limit);

    // Byte step: next state and up to two tokens.
    always_comb
    begin
        mode_next  = mode_e;
        depth_next = depth_e;
        acc_next   = acc_e;
        cnt_next   = cnt_e;
        neg_next   = neg_e;
        rem_next   = rem_e;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(depth_e - DW'(1));
        wr_data    = top_reg;
        v0         = 1'b0;
        v1         = 1'b0;
        t0         = '0;
        t1         = '0;
        t0.nest_level = 9'(depth_e);

        case (mode_e)
            MODE_EXPECT:
            begin
                if ((c == "e") && ((ctx == bsp_pkg::CTX_LIST) || (ctx == bsp_pkg::CTX_KEY)))
                begin
                    depth_next    = depth_e - DW'(1);
                    v0            = 1'b1;
                    t0.token_kind = bsp_pkg::KIND_END;
                    t0.nest_level = 9'(depth_next);
                    if (depth_next == '0)
                    begin
                        mode_next       = MODE_DONE;
                        t0.message_done = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_EXPECT;
                        case (below)
                            bsp_pkg::CTX_KEY: top_next = bsp_pkg::CTX_VAL;
                            bsp_pkg::CTX_VAL: top_next = bsp_pkg::CTX_KEY;
                            default:          top_next = below;
                        endcase
                    end
                end
                else if (depth_e >= DW'(bsp_pkg::MaxDepth))
                begin
                    v0            = 1'b1;
                    t0.token_kind = bsp_pkg::KIND_ERR;
                    t0.error_code = bsp_pkg::ERR_DEEP;
                    mode_next     = MODE_FAILED;
                end
                else if ((ctx == bsp_pkg::CTX_KEY) && ((c == "b") || (c == "d") || (c == "l")))
                begin
                    v0            = 1'b1;
                    t0.token_kind = bsp_pkg::KIND_ERR;
                    t0.error_code = bsp_pkg::ERR_KEY;
                    mode_next     = MODE_FAILED;
                end
                else if (is_digit)
                begin
                    acc_next  = {60'd0, dval};
                    cnt_next  = CW'(1);
                    mode_next = MODE_LEN;
                end
                else if (c == "b")
                begin
                    mode_next = MODE_BOOL;
                end
                else if (c == "i")
                begin
                    acc_next  = '0;
                    cnt_next  = '0;
                    neg_next  = 1'b0;
                    mode_next = MODE_INT_LEAD;
                end
                else if ((c == "l") || (c == "d"))
                begin
                    v0            = 1'b1;
                    t0.token_kind = (c == "l") ? bsp_pkg::KIND_LIST : bsp_pkg::KIND_DICT;
                    top_next      = (c == "l") ? bsp_pkg::CTX_LIST : bsp_pkg::CTX_KEY;
                    wr_en         = (depth_e != '0);
                    depth_next    = depth_e + DW'(1);
                    mode_next     = MODE_EXPECT;
                end
                else
                begin
                    v0            = 1'b1;
                    t0.token_kind = bsp_pkg::KIND_ERR;
                    t0.error_code = bsp_pkg::ERR_UNKNOWN;
                    mode_next     = MODE_FAILED;
                end
            end

            MODE_INT_LEAD, MODE_INT_SIGN, MODE_INT_DIG:
            begin
                if (c == "e")
                begin
                    v0 = 1'b1;
                    if (mode_e == MODE_INT_DIG)
                    begin
                        t0.token_kind  = bsp_pkg::KIND_INT;
                        t0.token_value = neg_e ? (64'd0 - acc_e) : acc_e;
                    end
                    else
                    begin
                        t0.token_kind = bsp_pkg::KIND_ERR;
                        t0.error_code = bsp_pkg::ERR_INT;
                        mode_next     = MODE_FAILED;
                    end
                end
                else if (cnt_e >= CW'(bsp_pkg::MaxNumberChars))
                begin
                    v0            = 1'b1;
                    t0.token_kind = bsp_pkg::KIND_ERR;
                    t0.error_code = bsp_pkg::ERR_INT;
                    mode_next     = MODE_FAILED;
                end
                else
                begin
                    cnt_next = cnt_e + CW'(1);
                    if (is_digit && fits)
                    begin
                        acc_next  = prod[63:0];
                        mode_next = MODE_INT_DIG;
                    end
                    else if (!is_digit && (mode_e == MODE_INT_LEAD) && is_ws)
                    begin
                        mode_next = MODE_INT_LEAD;
                    end
                    else if (!is_digit && (mode_e == MODE_INT_LEAD) &&
                             ((c == "+") || (c == "-")))
                    begin
                        neg_next  = (c == "-");
                        mode_next = MODE_INT_SIGN;
                    end
                    else
                    begin
                        v0            = 1'b1;
                        t0.token_kind = bsp_pkg::KIND_ERR;
                        t0.error_code = bsp_pkg::ERR_INT;
                        mode_next     = MODE_FAILED;
                    end
                end
            end

            MODE_LEN:
            begin
                if (c == ":")
                begin
                    rem_next       = acc_e;
                    mode_next      = MODE_STR;
                    v0             = 1'b1;
                    t0.token_kind  = bsp_pkg::KIND_HDR;
                    t0.token_value = acc_e;
                end
                else if ((cnt_e >= CW'(bsp_pkg::MaxNumberChars)) || !is_digit || !fits)
                begin
                    v0            = 1'b1;
                    t0.token_kind = bsp_pkg::KIND_ERR;
                    t0.error_code = bsp_pkg::ERR_LEN;
                    mode_next     = MODE_FAILED;
                    cnt_next      = cnt_e + CW'(is_digit);
                end
                else
                begin
                    cnt_next = cnt_e + CW'(1);
                    acc_next = prod[63:0];
                end
            end

            MODE_STR:
            begin
                rem_next       = rem_e - 64'd1;
                v0             = 1'b1;
                t0.token_kind  = bsp_pkg::KIND_BYTE;
                t0.token_value = {56'd0, c};
            end

            MODE_BOOL:
            begin
                v0 = 1'b1;
                if ((c == "0") || (c == "1"))
                begin
                    t0.token_kind  = bsp_pkg::KIND_BOOL;
                    t0.token_value = {63'd0, c[0]};
                end
                else
                begin
                    t0.token_kind = bsp_pkg::KIND_ERR;
                    t0.error_code = bsp_pkg::ERR_BOOL;
                    mode_next     = MODE_FAILED;
                end
            end

            default:
            begin
                mode_next = mode_e;
            end
        endcase

        // Completion of a scalar value: int, bool, last string byte, empty string.
        if (v0 && (((t0.token_kind == bsp_pkg::KIND_INT) ||
                    (t0.token_kind == bsp_pkg::KIND_BOOL)) ||
                   ((t0.token_kind == bsp_pkg::KIND_BYTE) && (rem_next == 64'd0)) ||
                   ((t0.token_kind == bsp_pkg::KIND_HDR) && (acc_e == 64'd0))))
        begin
            if (depth_e == '0)
            begin
                mode_next       = MODE_DONE;
                t0.message_done = 1'b1;
            end
            else
            begin
                mode_next = MODE_EXPECT;
                case (top_reg)
                    bsp_pkg::CTX_KEY: top_next = bsp_pkg::CTX_VAL;
                    bsp_pkg::CTX_VAL: top_next = bsp_pkg::CTX_KEY;
                    default:          top_next = top_reg;
                endcase
            end
        end

        // Truncation at the final byte of the data.
        if (byte_in.last_byte && (mode_next != MODE_DONE) && (mode_next != MODE_FAILED))
        begin
            mode_next = MODE_FAILED;
            if (v0)
            begin
                v1            = 1'b1;
                t1.token_kind = bsp_pkg::KIND_ERR;
                t1.error_code = bsp_pkg::ERR_TRUNC;
                t1.nest_level = 9'(depth_next);
            end
            else
            begin
                v0            = 1'b1;
                t0            = '0;
                t0.token_kind = bsp_pkg::KIND_ERR;
                t0.error_code = bsp_pkg::ERR_TRUNC;
                t0.nest_level = 9'(depth_next);
            end
        end

        t0.last_of_run = !v1;
        t1.last_of_run = 1'b1;
    end

    // Prefetch the entry below the top as it will stand after this cycle.
    assign rd_addr = accept ? AW'(depth_next - DW'(2)) : AW'(depth_reg - DW'(2));

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_EXPECT;
            depth_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            rem_reg   <= '0;
            top_reg   <= bsp_pkg::CTX_LIST;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                depth_reg <= depth_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                neg_reg   <= neg_next;
                rem_reg   <= rem_next;
                top_reg   <= top_next;
            end
            fwd_reg <= accept && wr_en && (wr_addr == rd_addr);
        end
    end

    // Stack memory: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rdata_reg    <= stack_mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    bsp_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (accept && v0),
        .push1     (accept && v1),
        .tok0      (t0),
        .tok1      (t1),
        .room      (room),
        .token_out (token_out)
    );

endmodule

// ===== src/bsp_token_fifo.sv =====
// ----------------------------------------------------------------------------
// bsp_token_fifo: four-entry token queue
// Takes up to two tokens a cycle and hands them out one per request.
// ----------------------------------------------------------------------------
module bsp_token_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push0,
    input  logic            push1,
    input  bsp_pkg::token_t tok0,
    input  bsp_pkg::token_t tok1,
    output logic            room,
    bsp_token_if.source     token_out
);

    bsp_pkg::token_t entry_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] n_push;
    bsp_pkg::token_t head_tok;

    // Room for a full pair of tokens.
    assign room = (count_reg <= 3'd2);
    assign pop  = token_out.valid && token_out.ready;
    assign n_push = {1'b0, push0} + {1'b0, push1};

    assign head_tok               = entry_reg[head_reg];
    assign token_out.valid        = (count_reg != 3'd0);
    assign token_out.token_kind   = head_tok.token_kind;
    assign token_out.token_value  = head_tok.token_value;
    assign token_out.nest_level   = head_tok.nest_level;
    assign token_out.error_code   = head_tok.error_code;
    assign token_out.message_done = head_tok.message_done;
    assign token_out.last_of_run  = head_tok.last_of_run;

    // Pointer and count update.
    always_comb
    begin
        head_next  = head_reg + {1'b0, pop};
        tail_next  = tail_reg + n_push;
        count_next = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[tail_reg] <= tok0;
        end
        if (push1)
        begin
            entry_reg[tail_reg + 2'd1] <= tok1;
        end
    end

endmodule

// ===== tb/tb_bsp_channels.sv =====
// ----------------------------------------------------------------------------
// tb_bsp_channels: channel helpers for the parser testbench
// Holds the byte request record that the stimulus side builds its messages from.
// ----------------------------------------------------------------------------
package tb_bsp_channels;

    // One byte request as offered on the input channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_req_t;

endpackage

// ===== tb/tb_bsp_checker.sv =====
// ----------------------------------------------------------------------------
// tb_bsp_checker: token predictor and scoreboard
// Follows every accepted byte request, predicts the tokens of the parser and
// compares each accepted token field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bsp_checker
    import bsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_data,
    input  logic        in_first,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  token_t      out_token,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser modes of the predictor.
    typedef enum int {
        PM_EXPECT, PM_INT_LEAD, PM_INT_SIGN, PM_INT_DIG, PM_LEN, PM_STR,
        PM_BOOL, PM_DONE, PM_FAILED
    } pmode_t;

    localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;

    ctx_t        ctx_stack [MaxDepth];
    int          depth;
    pmode_t      pmode;
    logic [63:0] acc;
    int          nchars;
    logic        neg;
    logic [63:0] str_left;
    token_t      token_q [$];
    token_t      run [$];

    assign pending = token_q.size();

    function automatic void push_token(kind_t k, logic [63:0] v, err_t e, logic d);
        token_t t;
        if (run.size() >= 2)
            return;
        t.token_kind   = k;
        t.token_value  = v;
        t.nest_level   = depth[8:0];
        t.error_code   = e;
        t.message_done = d;
        t.last_of_run  = 1'b0;
        run.push_back(t);
    endfunction

    function automatic void abort(err_t e);
        push_token(KIND_ERR, '0, e, 1'b0);
        pmode = PM_FAILED;
    endfunction

    // Closes one value; returns 1 when it completes the top-level value.
    function automatic logic close_value();
        if (depth == 0) begin
            pmode = PM_DONE;
            return 1'b1;
        end
        if (ctx_stack[depth-1] == CTX_KEY)
            ctx_stack[depth-1] = CTX_VAL;
        else if (ctx_stack[depth-1] == CTX_VAL)
            ctx_stack[depth-1] = CTX_KEY;
        pmode = PM_EXPECT;
        return 1'b0;
    endfunction

    function automatic logic digit_fits(logic [63:0] lim, int d);
        if (acc > (lim - d) / 10)
            return 1'b0;
        acc = acc * 10 + d;
        return 1'b1;
    endfunction

    function automatic void start_value(logic [7:0] c);
        ctx_t ctx;
        logic d;
        ctx = (depth > 0) ? ctx_stack[depth-1] : CTX_NONE;
        if (c == "e" && (ctx == CTX_LIST || ctx == CTX_KEY)) begin
            depth--;
            d = close_value();
            push_token(KIND_END, '0, ERR_UNKNOWN, d);
        end else if (depth >= MaxDepth) begin
            abort(ERR_DEEP);
        end else if (ctx == CTX_KEY && (c == "b" || c == "d" || c == "l")) begin
            abort(ERR_KEY);
        end else if (c >= "0" && c <= "9") begin
            acc    = c - "0";
            nchars = 1;
            pmode  = PM_LEN;
        end else if (c == "b") begin
            pmode = PM_BOOL;
        end else if (c == "i") begin
            acc    = '0;
            nchars = 0;
            neg    = 1'b0;
            pmode  = PM_INT_LEAD;
        end else if (c == "l" || c == "d") begin
            push_token(c == "l" ? KIND_LIST : KIND_DICT, '0, ERR_UNKNOWN, 1'b0);
            ctx_stack[depth] = (c == "l") ? CTX_LIST : CTX_KEY;
            depth++;
            pmode = PM_EXPECT;
        end else begin
            abort(ERR_UNKNOWN);
        end
    endfunction

    function automatic void int_char(logic [7:0] c);
        logic d;
        if (c == "e") begin
            if (pmode == PM_INT_DIG) begin
                d = close_value();
                push_token(KIND_INT, neg ? -acc : acc, ERR_UNKNOWN, d);
            end else begin
                abort(ERR_INT);
            end
        end else if (nchars >= MaxNumberChars) begin
            abort(ERR_INT);
        end else begin
            nchars++;
            if (c >= "0" && c <= "9") begin
                if (!digit_fits(neg ? NegLimit : PosLimit, c - "0"))
                    abort(ERR_INT);
                else
                    pmode = PM_INT_DIG;
            end else if (pmode == PM_INT_LEAD && (c == " " || (c >= 9 && c <= 13))) begin
                // Leading whitespace is skipped.
            end else if (pmode == PM_INT_LEAD && (c == "+" || c == "-")) begin
                neg   = (c == "-");
                pmode = PM_INT_SIGN;
            end else begin
                abort(ERR_INT);
            end
        end
    endfunction

    // Predicts the tokens of one accepted byte request.
    function automatic void predict_tokens(logic [7:0] c, logic first, logic last);
        logic d;
        run.delete();
        if (first) begin
            depth    = 0;
            pmode    = PM_EXPECT;
            acc      = '0;
            nchars   = 0;
            neg      = 1'b0;
            str_left = '0;
        end
        case (pmode)
            PM_EXPECT: start_value(c);
            PM_INT_LEAD, PM_INT_SIGN, PM_INT_DIG: int_char(c);
            PM_LEN:
            begin
                if (c == ":") begin
                    d        = 1'b0;
                    str_left = acc;
                    pmode    = PM_STR;
                    if (str_left == 0)
                        d = close_value();
                    push_token(KIND_HDR, acc, ERR_UNKNOWN, d);
                end else if (nchars >= MaxNumberChars || c < "0" || c > "9") begin
                    abort(ERR_LEN);
                end else begin
                    nchars++;
                    if (!digit_fits(PosLimit, c - "0"))
                        abort(ERR_LEN);
                end
            end
            PM_STR:
            begin
                str_left--;
                d = 1'b0;
                if (str_left == 0)
                    d = close_value();
                push_token(KIND_BYTE, {56'd0, c}, ERR_UNKNOWN, d);
            end
            PM_BOOL:
            begin
                if (c == "0" || c == "1") begin
                    d = close_value();
                    push_token(KIND_BOOL, {63'd0, c == "1"}, ERR_UNKNOWN, d);
                end else begin
                    abort(ERR_BOOL);
                end
            end
            default: ;
        endcase
        if (last && pmode != PM_DONE && pmode != PM_FAILED)
            abort(ERR_TRUNC);
        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i])
            token_q.push_back(run[i]);
    endfunction

    // Sample both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        token_t exp_tok;
        if (!rst_n) begin
            depth      = 0;
            pmode      = PM_EXPECT;
            acc        = '0;
            nchars     = 0;
            neg        = 1'b0;
            str_left   = '0;
            mismatches <= 0;
            token_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (token_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected token %p", out_token);
                end else begin
                    exp_tok = token_q.pop_front();
                    if (out_token !== exp_tok) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("token mismatch: expected %p, got %p",
                                     exp_tok, out_token);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_tokens(in_data, in_first, in_last);
        end
    end

endmodule

// ===== tb/tb_bencode_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tb_bencode_stream_parser: testbench top of the bencode stream parser
// Drives directed and random byte messages with random gaps and stalls and
// takes its verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_bencode_stream_parser;
    import bsp_pkg::*;
    import tb_bsp_channels::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          pending;
    int          idle_cycles;
    logic        stall_long;
    byte_req_t   msg [$];
    token_t      out_token;

    bsp_byte_if  byte_ch ();
    bsp_token_if token_ch ();

    bencode_stream_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch.sink),
        .token_out (token_ch.source)
    );

    assign out_token = '{token_ch.token_kind, token_ch.token_value, token_ch.nest_level,
                         token_ch.error_code, token_ch.message_done,
                         token_ch.last_of_run};

    tb_bsp_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_ch.valid),
        .in_ready   (byte_ch.ready),
        .in_data    (byte_ch.data_byte),
        .in_first   (byte_ch.first_byte),
        .in_last    (byte_ch.last_byte),
        .out_valid  (token_ch.valid),
        .out_ready  (token_ch.ready),
        .out_token  (out_token),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // Appends a string of bytes to the message under construction.
    function automatic void put_text(string s);
        foreach (s[i])
            msg.push_back('{s[i], 1'b0, 1'b0});
    endfunction

    // Builds a random well-formed value of limited depth.
    function automatic void put_value(int lvl, logic as_key);
        int sel, n;
        sel = as_key ? $urandom_range(0, 1) : $urandom_range(0, 4);
        case (sel)
            0:
            begin
                case ($urandom_range(0, 5))
                    0: put_text("i-9223372036854775808e");
                    1: put_text("i9223372036854775807e");
                    2: put_text("i \t+0e");
                    default: put_text($sformatf("i%0de", $signed($urandom())));
                endcase
            end
            1:
            begin
                n = $urandom_range(0, 4);
                put_text($sformatf("%0d:", n));
                repeat (n)
                    msg.push_back('{8'($urandom()), 1'b0, 1'b0});
            end
            2: put_text($urandom_range(0, 1) ? "b1" : "b0");
            default:
            begin
                n = (lvl > 3) ? 0 : $urandom_range(0, 3);
                if (sel == 3) begin
                    put_text("l");
                    repeat (n)
                        put_value(lvl + 1, 1'b0);
                end else begin
                    put_text("d");
                    repeat (n)
                    begin
                        put_value(lvl + 1, 1'b1);
                        put_value(lvl + 1, 1'b0);
                    end
                end
                put_text("e");
            end
        endcase
    endfunction

    // Sends the queued message with random gaps, first mark on its first byte.
    task automatic send_msg(logic mark_last);
        int g;
        if (msg.size() == 0)
            return;
        msg[0].first_byte = 1'b1;
        if (mark_last)
            msg[msg.size()-1].last_byte = 1'b1;
        while (msg.size() > 0)
        begin
            g = gap_len();
            if (g > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
            byte_ch.valid      <= 1'b1;
            byte_ch.data_byte  <= msg[0].data_byte;
            byte_ch.first_byte <= msg[0].first_byte;
            byte_ch.last_byte  <= msg[0].last_byte;
            @(posedge clk);
            while (!byte_ch.ready)
                @(posedge clk);
            void'(msg.pop_front());
        end
        byte_ch.valid <= 1'b0;
    endtask

    task automatic send_text(string s, logic mark_last);
        put_text(s);
        send_msg(mark_last);
    endtask

    // Receiver side: random stalls plus one long hold-off on request.
    initial
    begin
        token_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_long) begin
                token_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                stall_long = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                token_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            token_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted request.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int  sel;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= '0;
        byte_ch.first_byte <= 1'b0;
        byte_ch.last_byte  <= 1'b0;
        stall_long = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages: extremes, every token kind and each error.
        send_text("i-9223372036854775808e", 1'b1);
        send_text("i9223372036854775808e", 1'b0);
        send_text("d3:keyl b1 i 7e0:ee", 1'b0);
        send_text("d3:keyli7eb0ee", 1'b1);
        send_text("di1eb1ee", 1'b0);
        send_text("dlee", 1'b0);
        send_text("b2", 1'b0);
        send_text("x", 1'b0);
        send_text("12a", 1'b0);
        send_text("i12", 1'b1);
        send_text("i123456789012345678901e", 1'b0);
        msg.push_back('{8'h00, 1'b0, 1'b0});
        send_msg(1'b0);
        send_text("4:\x80\xff", 1'b1);
        send_text("i1eXYZ", 1'b0);
        for (int i = 0; i < 256; i++)
            put_text("l");
        put_text("i0e");
        send_msg(1'b0);

        // Long receiver hold-off while bytes keep coming.
        stall_long = 1'b1;
        for (int i = 0; i < 40; i++)
            put_text("l");
        put_text("e");
        send_msg(1'b1);

        // Sender pauses until every expected token has come.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random part: mostly well-formed messages, some broken or noise.
        for (int m = 0; m < 45; m++)
        begin
            sel = $urandom_range(0, 9);
            put_value(0, 1'b0);
            if (sel == 0) begin
                repeat ($urandom_range(1, 4))
                    msg.push_back('{8'($urandom()), 1'b0, 1'b0});
            end else if (sel == 1 && msg.size() > 1) begin
                msg[$urandom_range(0, msg.size()-1)].data_byte = 8'($urandom());
            end else if (sel == 2) begin
                msg = msg[0:$urandom_range(0, msg.size()-1)];
            end
            send_msg(sel == 2 || sel == 3);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
